// File: rtl/tmaa_pkg.sv
// Shared types and constants of the triangle mesh area accumulator.
package tmaa_pkg;

  localparam int IDX_W       = 10;
  localparam int COORD_IN_W  = 16;
  localparam int SUM_W       = 48;
  localparam int S_TDATA_W   = IDX_W + 3 * COORD_IN_W + 3 * IDX_W;
  localparam int M_TDATA_W   = SUM_W;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic {
    OP_VERTEX   = 1'b0,
    OP_TRIANGLE = 1'b1
  } op_e;

  // Order in which the three coordinate products are formed per axis.
  typedef enum logic [1:0] {
    KIND_BB,
    KIND_CC,
    KIND_BC
  } dot_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_READ_C,
    ST_DIFF,
    ST_DOT_START,
    ST_DOT_WAIT,
    ST_P_START,
    ST_P_WAIT,
    ST_Q_START,
    ST_Q_WAIT,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_ACCUM
  } tmaa_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic             last;
  } tri_req_t;

endpackage

// File: rtl/tmaa_vstore.sv
// Vertex store: one write port, one registered read port.
module tmaa_vstore #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tmaa_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module tmaa_mul #(
  parameter int MW = 34
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(MW+1)-1:0]    len_i,   // multiplier bits to consume
  input  logic [MW-1:0]              a_i,
  input  logic [MW-1:0]              b_i,     // multiplier, aligned to the top
  output logic                       done_o,
  output logic [2*MW-1:0]            prod_o
);

  localparam int CW = $clog2(MW + 1);
  localparam int PW = 2 * MW;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [MW-1:0] ma_q, ma_d;
  logic [MW-1:0] mb_q, mb_d;

  always_comb begin
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = len_i;
      acc_d = '0;
      ma_d  = a_i;
      mb_d  = b_i;
    end else if (cnt_q != '0) begin
      // shift in one partial product per step
      acc_d  = {acc_q[PW-2:0], 1'b0} + (mb_q[MW-1] ? PW'(ma_q) : '0);
      mb_d   = {mb_q[MW-2:0], 1'b0};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/tmaa_sqrt.sv
// Restoring integer square root, one root bit (two radicand bits) per cycle.
module tmaa_sqrt #(
  parameter int MW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*MW-1:0] rad_i,
  output logic            done_o,
  output logic [MW-1:0]   root_o
);

  localparam int CW = $clog2(MW + 1);
  localparam int RW = MW + 2;

  logic [CW-1:0]   cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [2*MW-1:0] rad_q, rad_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [MW-1:0]   root_q, root_d;
  logic [RW:0]     rem_x;
  logic [RW:0]     trial;
  logic [RW:0]     diff;

  assign rem_x = {rem_q[MW:0], rad_q[2*MW-1 -: 2]};
  assign trial = (RW+1)'({root_q, 2'b01});
  assign diff  = rem_x - trial;

  always_comb begin
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = CW'(MW);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[2*MW-3:0], 2'b00};
      if (rem_x >= trial) begin
        rem_d  = diff[RW-1:0];
        root_d = {root_q[MW-2:0], 1'b1};
      end else begin
        rem_d  = rem_x[RW-1:0];
        root_d = {root_q[MW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/triangle_mesh_area_accumulator_unit.sv
// Top level: vertex store, area sequencer and saturating mesh area sum.
// A triangle request runs nine short products and two long ones on the shared
// bit-serial multiplier, then the bit-serial root. Input is refused while a
// triangle is in work; a finished total waits in the output register, and
// only the next last triangle holds in its final step until that register
// empties. Reset clears the sum, the saturation flag and the sequencer; the
// vertex store holds garbage until written.
module triangle_mesh_area_accumulator_unit
  import tmaa_pkg::*;
#(
  parameter int VERTEX_DEPTH = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [9:0] vertex_index, [25:10] coord_x, [41:26] coord_y, [57:42] coord_z,
  // [67:58] corner_a, [77:68] corner_b, [87:78] corner_c
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,   // [0] operation
  input  logic                 s_axis_tlast,   // last_triangle
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [47:0] mesh_area
  output logic [0:0]           m_axis_tuser    // [0] overflowed
);

  localparam int AW     = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int W      = COORD_WIDTH;
  localparam int DW     = W + 1;          // edge component
  localparam int MW     = 2 * W + 2;      // dot product magnitude
  localparam int PW     = 2 * MW;         // radicand
  localparam int CW     = $clog2(MW + 1);
  localparam int VW     = 3 * W;
  localparam int AREA_W = MW - 1;
  localparam int ADD_W  = ((AREA_W > SUM_W) ? AREA_W : SUM_W) + 1;

  // unpack the request
  logic [IDX_W-1:0]      vertex_index;
  logic [COORD_IN_W-1:0] coord_x, coord_y, coord_z;
  tri_req_t              tri_in;
  logic                  in_accept;

  assign vertex_index    = s_axis_tdata[9:0];
  assign coord_x         = s_axis_tdata[25:10];
  assign coord_y         = s_axis_tdata[41:26];
  assign coord_z         = s_axis_tdata[57:42];
  assign tri_in.corner_a = s_axis_tdata[67:58];
  assign tri_in.corner_b = s_axis_tdata[77:68];
  assign tri_in.corner_c = s_axis_tdata[87:78];
  assign tri_in.last     = s_axis_tlast;
  assign in_accept       = s_axis_tvalid && s_axis_tready;

  tmaa_state_e state_q, state_d;
  tri_req_t    tri_q;

  // vertex store; slots at or beyond the depth are dropped on write
  logic          mem_we;
  logic [VW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [VW-1:0] mem_rdata;
  logic          rd_ok_d, rd_ok_q;

  assign mem_we    = in_accept && (op_e'(s_axis_tuser[0]) == OP_VERTEX)
                     && (32'(vertex_index) < VERTEX_DEPTH);
  assign mem_wdata = {W'(coord_z), W'(coord_y), W'(coord_x)};

  tmaa_vstore #(
    .DEPTH (VERTEX_DEPTH),
    .AW    (AW),
    .DW    (VW)
  ) u_vstore (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(vertex_index)),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // a corner outside the store reads as the origin
  logic [VW-1:0]        rd_word;
  logic signed [W-1:0]  rd_coord [3];
  logic signed [W-1:0]  va_q [3];
  logic signed [W-1:0]  vb_q [3];
  logic signed [DW-1:0] ab_q [3];
  logic signed [DW-1:0] ac_q [3];

  assign rd_word = rd_ok_q ? mem_rdata : '0;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_coord[k] = $signed(rd_word[k*W +: W]);
    end
  end

  // dot products, accumulated one product at a time
  logic [1:0]           comp_q;
  dot_kind_e            kind_q;
  logic                 neg_q;
  logic [MW-1:0]        dbb_q, dcc_q;
  logic signed [MW:0]   dbc_q;
  logic signed [DW-1:0] opx, opy;
  logic [DW-1:0]        magx, magy;
  logic [MW-1:0]        mbc;
  logic                 dot_last;

  assign opx  = (kind_q == KIND_CC) ? ac_q[comp_q] : ab_q[comp_q];
  assign opy  = (kind_q == KIND_BB) ? ab_q[comp_q] : ac_q[comp_q];
  assign magx = opx[DW-1] ? DW'(-opx) : DW'(opx);
  assign magy = opy[DW-1] ? DW'(-opy) : DW'(opy);
  assign mbc  = dbc_q[MW] ? MW'(-dbc_q) : MW'(dbc_q);
  assign dot_last = (comp_q == 2'd2) && (kind_q == KIND_BC);

  // shared multiplier and root unit
  logic            mul_start;
  logic [CW-1:0]   mul_len;
  logic [MW-1:0]   mul_a, mul_b;
  logic            mul_done;
  logic [PW-1:0]   mul_prod;
  logic [MW-1:0]   pt;

  assign pt = mul_prod[MW-1:0];

  tmaa_mul #(
    .MW (MW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .len_i   (mul_len),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  logic [PW-1:0] p_q;
  logic [PW:0]   rad_diff;
  logic [PW-1:0] rad_q;
  logic          sqrt_start;
  logic          sqrt_done;
  logic [MW-1:0] root;

  // clamp a negative radicand to zero
  assign rad_diff = {1'b0, p_q} - {1'b0, mul_prod};

  tmaa_sqrt #(
    .MW (MW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // saturating running sum
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             sat_q, sat_d;
  logic [ADD_W-1:0] sum_wide;
  logic             sum_over;
  logic [SUM_W-1:0] sum_next;
  logic             out_load;
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_area_q;
  logic             out_ovf_q;

  assign sum_wide = ADD_W'(sum_q) + ADD_W'(root[MW-1:1]);
  assign sum_over = sum_wide > ADD_W'(SUM_MAX);
  assign sum_next = sum_over ? SUM_MAX : sum_wide[SUM_W-1:0];

  // sequencer: next state and unit controls
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    mem_raddr     = AW'(tri_q.corner_a);
    rd_ok_d       = 1'b0;
    mul_start     = 1'b0;
    mul_len       = CW'(DW);
    mul_a         = MW'(magx);
    mul_b         = MW'(magy) << (MW - DW);
    sqrt_start    = 1'b0;
    out_load      = 1'b0;
    sum_d         = sum_q;
    sat_d         = sat_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept && (op_e'(s_axis_tuser[0]) == OP_TRIANGLE)) begin
          state_d = ST_READ_A;
        end
      end
      ST_READ_A: begin
        mem_raddr = AW'(tri_q.corner_a);
        rd_ok_d   = 32'(tri_q.corner_a) < VERTEX_DEPTH;
        state_d   = ST_READ_B;
      end
      ST_READ_B: begin
        mem_raddr = AW'(tri_q.corner_b);
        rd_ok_d   = 32'(tri_q.corner_b) < VERTEX_DEPTH;
        state_d   = ST_READ_C;
      end
      ST_READ_C: begin
        mem_raddr = AW'(tri_q.corner_c);
        rd_ok_d   = 32'(tri_q.corner_c) < VERTEX_DEPTH;
        state_d   = ST_DIFF;
      end
      ST_DIFF: begin
        state_d = ST_DOT_START;
      end
      ST_DOT_START: begin
        mul_start = 1'b1;
        state_d   = ST_DOT_WAIT;
      end
      ST_DOT_WAIT: begin
        if (mul_done) begin
          state_d = dot_last ? ST_P_START : ST_DOT_START;
        end
      end
      ST_P_START: begin
        mul_start = 1'b1;
        mul_len   = CW'(MW);
        mul_a     = dbb_q;
        mul_b     = dcc_q;
        state_d   = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (mul_done) begin
          state_d = ST_Q_START;
        end
      end
      ST_Q_START: begin
        mul_start = 1'b1;
        mul_len   = CW'(MW);
        mul_a     = mbc;
        mul_b     = mbc;
        state_d   = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (mul_done) begin
          state_d = ST_SQRT_START;
        end
      end
      ST_SQRT_START: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (!tri_q.last) begin
          sum_d   = sum_next;
          sat_d   = sat_q | sum_over;
          state_d = ST_IDLE;
        end else if (!out_valid_q || m_axis_tready) begin
          // emit the total, then start a fresh mesh
          out_load = 1'b1;
          sum_d    = '0;
          sat_d    = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, loaded by sequencer state
  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok_d;
    if (out_load) begin
      out_area_q <= sum_next;
      out_ovf_q  <= sat_q | sum_over;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          tri_q <= tri_in;
        end
      end
      ST_READ_B: begin
        va_q <= rd_coord;
      end
      ST_READ_C: begin
        vb_q <= rd_coord;
      end
      ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          ab_q[k] <= DW'(vb_q[k]) - DW'(va_q[k]);
          ac_q[k] <= DW'(rd_coord[k]) - DW'(va_q[k]);
        end
        dbb_q  <= '0;
        dcc_q  <= '0;
        dbc_q  <= '0;
        comp_q <= 2'd0;
        kind_q <= KIND_BB;
      end
      ST_DOT_START: begin
        neg_q <= opx[DW-1] ^ opy[DW-1];
      end
      ST_DOT_WAIT: begin
        if (mul_done) begin
          case (kind_q)
            KIND_BB: begin
              dbb_q  <= dbb_q + pt;
              kind_q <= KIND_CC;
            end
            KIND_CC: begin
              dcc_q  <= dcc_q + pt;
              kind_q <= KIND_BC;
            end
            KIND_BC: begin
              if (neg_q) begin
                dbc_q <= dbc_q - $signed({1'b0, pt});
              end else begin
                dbc_q <= dbc_q + $signed({1'b0, pt});
              end
              kind_q <= KIND_BB;
              comp_q <= comp_q + 2'd1;
            end
            default: begin
              kind_q <= KIND_BB;
            end
          endcase
        end
      end
      ST_P_WAIT: begin
        if (mul_done) begin
          p_q <= mul_prod;
        end
      end
      ST_Q_WAIT: begin
        if (mul_done) begin
          rad_q <= rad_diff[PW] ? '0 : rad_diff[PW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_area_q;
  assign m_axis_tuser[0] = out_ovf_q;

endmodule
